// ----- rtl/core/cmvm_pkg.sv -----
`timescale 1ns / 1ps

package cmvm_pkg;

   localparam int MAX_ROWS_DEF = 64;
   localparam int MAX_COLS_DEF = 64;

   localparam int VAL_W = 16;
   localparam int SUM_W = 40;
   localparam int POS_W = 12;
   localparam int ROW_W = 6;
   localparam int CFG_W = 7;

   localparam logic [CFG_W-1:0] CFG_RESET = 7'd64;

   localparam logic CSR_ROW_COUNT = 1'b0;
   localparam logic CSR_COL_COUNT = 1'b1;

   typedef struct packed {
      logic                    mode;
      logic [POS_W-1:0]        position;
      logic signed [VAL_W-1:0] value_real;
      logic signed [VAL_W-1:0] value_imag;
   } req_type;

   typedef struct packed {
      logic [ROW_W-1:0]        row_index;
      logic signed [SUM_W-1:0] sum_real;
      logic signed [SUM_W-1:0] sum_imag;
      logic                    last_row;
   } rsp_type;

   typedef struct packed {
      logic             write_matrix;
      logic             write_vector;
      logic             issue;
      logic             new_product;
      logic             new_row;
      logic             end_row;
      logic             final_row;
      logic [ROW_W-1:0] row;
   } cmd_type;

   typedef struct packed {
      logic final_result;
   } status_type;

   function automatic logic [CFG_W-1:0] clamp_count(input logic [CFG_W-1:0] v,
                                                    input int unsigned max);
      logic [CFG_W-1:0] r;
      r = v;
      if (v == '0) begin
         r = CFG_W'(1);
      end else if (32'(v) > max) begin
         r = CFG_W'(max);
      end
      return r;
   endfunction

endpackage

// ----- rtl/core/complex_matrix_vector_multiply.sv -----
`timescale 1ns / 1ps
// An item that writes a matrix or vector element leaves busy low. The vector item for the
// last used column starts the product: busy goes high, one complex multiply-accumulate per
// cycle through a single MAC. Each row's result gets one strobe, in row order; it cannot stall.
// Synchronous reset sets both counts to 64, clamped to MAX_ROWS and MAX_COLS, and idles the
// controller; stores are not cleared.

module complex_matrix_vector_multiply #(
   parameter int MAX_ROWS = cmvm_pkg::MAX_ROWS_DEF,
   parameter int MAX_COLS = cmvm_pkg::MAX_COLS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  cmvm_pkg::req_type           req_data,
   output logic                        rsp_strobe,
   output cmvm_pkg::rsp_type           rsp_data,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic                        csr_index,
   input  logic [cmvm_pkg::CFG_W-1:0]  csr_data
);

   cmvm_pkg::cmd_type    cmd;
   cmvm_pkg::status_type status;

   cmvm_ctrl #(
      .MAX_ROWS (MAX_ROWS),
      .MAX_COLS (MAX_COLS)
   ) u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .busy         (busy),
      .req_mode     (req_data.mode),
      .req_position (req_data.position),
      .csr_valid    (csr_valid),
      .csr_ready    (csr_ready),
      .csr_index    (csr_index),
      .csr_data     (csr_data),
      .cmd          (cmd),
      .status       (status)
   );

   cmvm_datapath #(
      .MAX_ROWS (MAX_ROWS),
      .MAX_COLS (MAX_COLS)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req        (req_data),
      .cmd        (cmd),
      .rsp_strobe (rsp_strobe),
      .rsp        (rsp_data),
      .status     (status)
   );

endmodule

// ----- rtl/core/cmvm_ram.sv -----
`timescale 1ns / 1ps

module cmvm_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/core/cmvm_ctrl.sv -----
`timescale 1ns / 1ps

module cmvm_ctrl #(
   parameter int MAX_ROWS = cmvm_pkg::MAX_ROWS_DEF,
   parameter int MAX_COLS = cmvm_pkg::MAX_COLS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic                        req_mode,
   input  logic [cmvm_pkg::POS_W-1:0]  req_position,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic                        csr_index,
   input  logic [cmvm_pkg::CFG_W-1:0]  csr_data,
   output cmvm_pkg::cmd_type           cmd,
   input  cmvm_pkg::status_type        status
);

   localparam int RW = $clog2(MAX_ROWS + 1);
   localparam int CW = $clog2(MAX_COLS + 1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_DRAIN
   } state_type;

   state_type                  state_ff;
   logic                       busy_ff;
   logic                       first_ff;
   logic [RW-1:0]              row_ff;
   logic [CW-1:0]              col_ff;
   logic [cmvm_pkg::CFG_W-1:0] rows_ff;
   logic [cmvm_pkg::CFG_W-1:0] cols_ff;

   logic accept;
   logic trigger;
   logic end_row;
   logic final_row;

   assign accept  = start & ~busy_ff;
   assign trigger = req_mode
                    & (32'(req_position) < 32'(MAX_COLS))
                    & (req_position == cmvm_pkg::POS_W'(cols_ff - 7'd1));
   assign end_row   = (col_ff == CW'(cols_ff - 7'd1));
   assign final_row = (row_ff == RW'(rows_ff - 7'd1));

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         busy_ff  <= 1'b0;
         first_ff <= 1'b0;
         row_ff   <= '0;
         col_ff   <= '0;
         rows_ff  <= cmvm_pkg::clamp_count(cmvm_pkg::CFG_RESET, MAX_ROWS);
         cols_ff  <= cmvm_pkg::clamp_count(cmvm_pkg::CFG_RESET, MAX_COLS);
      end else begin
         if (csr_valid && csr_ready) begin
            if (csr_index == cmvm_pkg::CSR_ROW_COUNT) begin
               rows_ff <= cmvm_pkg::clamp_count(csr_data, MAX_ROWS);
            end else begin
               cols_ff <= cmvm_pkg::clamp_count(csr_data, MAX_COLS);
            end
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (accept && trigger) begin
                  state_ff <= ST_RUN;
                  busy_ff  <= 1'b1;
                  first_ff <= 1'b1;
                  row_ff   <= '0;
                  col_ff   <= '0;
               end
            end
            ST_RUN: begin
               first_ff <= 1'b0;
               if (end_row) begin
                  col_ff <= '0;
                  if (final_row) begin
                     state_ff <= ST_DRAIN;
                  end else begin
                     row_ff <= row_ff + RW'(1);
                  end
               end else begin
                  col_ff <= col_ff + CW'(1);
               end
            end
            ST_DRAIN: begin
               if (status.final_result) begin
                  state_ff <= ST_IDLE;
                  busy_ff  <= 1'b0;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
               busy_ff  <= 1'b0;
            end
         endcase
      end
   end

   assign busy      = busy_ff;
   assign csr_ready = ~busy_ff;

   always_comb begin
      cmd.write_matrix = accept & ~req_mode;
      cmd.write_vector = accept & req_mode;
      cmd.issue        = (state_ff == ST_RUN);
      cmd.new_product  = first_ff;
      cmd.new_row      = (col_ff == '0);
      cmd.end_row      = end_row;
      cmd.final_row    = final_row;
      cmd.row          = cmvm_pkg::ROW_W'(row_ff);
   end

endmodule

// ----- rtl/core/cmvm_datapath.sv -----
`timescale 1ns / 1ps

module cmvm_datapath #(
   parameter int MAX_ROWS = cmvm_pkg::MAX_ROWS_DEF,
   parameter int MAX_COLS = cmvm_pkg::MAX_COLS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  cmvm_pkg::req_type     req,
   input  cmvm_pkg::cmd_type     cmd,
   output logic                  rsp_strobe,
   output cmvm_pkg::rsp_type     rsp,
   output cmvm_pkg::status_type  status
);

   localparam int MAT_DEPTH = MAX_ROWS * MAX_COLS;
   localparam int MAW = (MAT_DEPTH > 1) ? $clog2(MAT_DEPTH) : 1;
   localparam int VAW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
   localparam int EW  = 2 * cmvm_pkg::VAL_W;
   localparam int SW  = cmvm_pkg::SUM_W;

   typedef struct packed {
      logic                       valid;
      logic                       first;
      logic                       last;
      logic                       final_row;
      logic [cmvm_pkg::ROW_W-1:0] row;
   } tag_type;

   logic [EW-1:0]  wr_data;
   logic           mat_we;
   logic           vec_we;
   logic [MAW-1:0] mat_rd_addr;
   logic [MAW-1:0] mat_addr_ff;
   logic [VAW-1:0] vec_rd_addr;
   logic [VAW-1:0] vec_addr_ff;
   logic [EW-1:0]  mat_rd_data;
   logic [EW-1:0]  vec_rd_data;

   tag_type tag1_ff, tag2_ff, tag3_ff;

   logic signed [cmvm_pkg::VAL_W-1:0] ar, ai, xr, xi;
   logic signed [EW-1:0]              p_rr_ff, p_ii_ff, p_ri_ff, p_ir_ff;
   logic signed [EW:0]                cre_ff, cim_ff;
   logic signed [SW-1:0]              acc_re_ff, acc_im_ff;
   logic signed [SW-1:0]              acc_re_in, acc_im_in;

   logic                       out_valid_ff;
   logic                       out_final_ff;
   logic [cmvm_pkg::ROW_W-1:0] out_row_ff;

   assign wr_data = {req.value_imag, req.value_real};
   assign mat_we  = cmd.write_matrix & (32'(req.position) < 32'(MAT_DEPTH));
   assign vec_we  = cmd.write_vector & (32'(req.position) < 32'(MAX_COLS));

   assign mat_rd_addr = cmd.new_product ? '0 : mat_addr_ff;
   assign vec_rd_addr = cmd.new_row ? '0 : vec_addr_ff;

   always_ff @(posedge clock) begin
      if (cmd.issue) begin
         mat_addr_ff <= mat_rd_addr + MAW'(1);
         vec_addr_ff <= vec_rd_addr + VAW'(1);
      end
   end

   cmvm_ram #(
      .WIDTH (EW),
      .DEPTH (MAT_DEPTH)
   ) u_matrix_ram (
      .clock   (clock),
      .wr_en   (mat_we),
      .wr_addr (MAW'(req.position)),
      .wr_data (wr_data),
      .rd_en   (cmd.issue),
      .rd_addr (mat_rd_addr),
      .rd_data (mat_rd_data)
   );

   cmvm_ram #(
      .WIDTH (EW),
      .DEPTH (MAX_COLS)
   ) u_vector_ram (
      .clock   (clock),
      .wr_en   (vec_we),
      .wr_addr (VAW'(req.position)),
      .wr_data (wr_data),
      .rd_en   (cmd.issue),
      .rd_addr (vec_rd_addr),
      .rd_data (vec_rd_data)
   );

   assign ar = mat_rd_data[cmvm_pkg::VAL_W-1:0];
   assign ai = mat_rd_data[EW-1:cmvm_pkg::VAL_W];
   assign xr = vec_rd_data[cmvm_pkg::VAL_W-1:0];
   assign xi = vec_rd_data[EW-1:cmvm_pkg::VAL_W];

   always_ff @(posedge clock) begin
      if (reset) begin
         tag1_ff <= '0;
         tag2_ff <= '0;
         tag3_ff <= '0;
      end else begin
         tag1_ff.valid     <= cmd.issue;
         tag1_ff.first     <= cmd.new_row;
         tag1_ff.last      <= cmd.end_row;
         tag1_ff.final_row <= cmd.final_row;
         tag1_ff.row       <= cmd.row;
         tag2_ff           <= tag1_ff;
         tag3_ff           <= tag2_ff;
      end
   end

   always_ff @(posedge clock) begin
      p_rr_ff <= ar * xr;
      p_ii_ff <= ai * xi;
      p_ri_ff <= ar * xi;
      p_ir_ff <= ai * xr;
      cre_ff  <= (EW+1)'(p_rr_ff) - (EW+1)'(p_ii_ff);
      cim_ff  <= (EW+1)'(p_ri_ff) + (EW+1)'(p_ir_ff);
   end

   assign acc_re_in = tag3_ff.first ? SW'(cre_ff) : acc_re_ff + SW'(cre_ff);
   assign acc_im_in = tag3_ff.first ? SW'(cim_ff) : acc_im_ff + SW'(cim_ff);

   always_ff @(posedge clock) begin
      if (tag3_ff.valid) begin
         acc_re_ff <= acc_re_in;
         acc_im_ff <= acc_im_in;
      end
      out_row_ff   <= tag3_ff.row;
      out_final_ff <= tag3_ff.final_row;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= tag3_ff.valid & tag3_ff.last;
      end
   end

   assign rsp_strobe          = out_valid_ff;
   assign rsp.row_index       = out_row_ff;
   assign rsp.sum_real        = acc_re_ff;
   assign rsp.sum_imag        = acc_im_ff;
   assign rsp.last_row        = out_final_ff;
   assign status.final_result = out_valid_ff & out_final_ff;

endmodule
